[hw/rtl/tncs_pkg.sv]
// Shared types, constants and sequencer states for the top-N cosine similarity search.
// Used by the top level and by the square root and divider units.
package tncs_pkg;

  localparam int DEF_MAX_REFERENCES = 1024;
  localparam int DEF_MAX_LENGTH     = 256;
  localparam int DEF_MAX_TOP        = 16;

  localparam int SQ_W    = 56;
  localparam int ROOT_W  = 28;
  localparam int ELEM_W  = 24;
  localparam int UNIT_W  = 16;
  localparam int CFG_W   = 9;

  localparam logic       CFG_VECTOR_LENGTH   = 1'b0;
  localparam logic       CFG_TOP_N           = 1'b1;
  localparam logic [8:0] RESET_VECTOR_LENGTH = 9'd256;
  localparam logic [4:0] RESET_TOP_N         = 5'd1;
  localparam logic       KIND_REFERENCE      = 1'b0;

  typedef struct packed {
    logic                     kind;
    logic signed [ELEM_W-1:0] element_value;
    logic                     last_element;
  } in_item_t;

  typedef struct packed {
    logic [23:0]              query_number;
    logic [3:0]               rank;
    logic [10:0]              reference_index;
    logic signed [UNIT_W-1:0] score;
    logic                     last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_WAIT,
    ST_ROOT,
    ST_NORM_RD,
    ST_NORM_DAT,
    ST_NORM_DIV,
    ST_SCAN,
    ST_ISSUE,
    ST_DRAIN,
    ST_RANK,
    ST_EMIT
  } state_e;

endpackage

[hw/rtl/tncs_root.sv]
// Iterative integer square root, two radicand bits per cycle.
// Depends on tncs_pkg for widths.
module tncs_root (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tncs_pkg::SQ_W-1:0]  x_i,
  output logic                       done_o,
  output logic [tncs_pkg::ROOT_W-1:0] root_o
);
  import tncs_pkg::*;

  logic [SQ_W-1:0] x_q, res_q, bit_q, sum;
  logic            busy_q, done_q;

  assign sum = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      res_q <= '0;
      bit_q <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_q) begin
      if (x_q >= sum) begin
        x_q   <= x_q - sum;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

[hw/rtl/tncs_div.sv]
// Restoring divider that turns one element into its unit-length Q1.15 value.
// One quotient bit per cycle. Depends on tncs_pkg for widths.
module tncs_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [tncs_pkg::ELEM_W-1:0] e_i,
  input  logic [tncs_pkg::ROOT_W-1:0]        r_i,
  output logic                              done_o,
  output logic signed [tncs_pkg::UNIT_W-1:0] q_o
);
  import tncs_pkg::*;

  localparam int QB = 17;
  localparam int NW = ELEM_W + 15;

  logic [ELEM_W-1:0] mag;
  logic [NW-1:0]     num;
  logic [ROOT_W-1:0] rem_q, r_q;
  logic [ROOT_W:0]   rem2;
  logic [QB-1:0]     bits_q, quo_q;
  logic              neg_q, busy_q, done_q;
  logic [4:0]        cnt_q;

  assign mag  = e_i[ELEM_W-1] ? (~e_i + 1'b1) : e_i;
  assign num  = {mag, 15'b0} + NW'(r_i >> 1);
  assign rem2 = {rem_q, bits_q[QB-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(QB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The quotient is known to stay below 2^17, so the upper bits seed the remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= ROOT_W'(num[NW-1:QB]);
      bits_q <= num[QB-1:0];
      r_q    <= r_i;
      neg_q  <= e_i[ELEM_W-1];
      quo_q  <= '0;
    end else if (busy_q) begin
      bits_q <= bits_q << 1;
      if (rem2 >= {1'b0, r_q}) begin
        rem_q <= ROOT_W'(rem2 - {1'b0, r_q});
        quo_q <= {quo_q[QB-2:0], 1'b1};
      end else begin
        rem_q <= rem2[ROOT_W-1:0];
        quo_q <= {quo_q[QB-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (neg_q) begin
      q_o = (quo_q > 17'd32768) ? -16'sd32768 : UNIT_W'(-quo_q);
    end else begin
      q_o = (quo_q > 17'd32767) ? 16'sd32767 : UNIT_W'(quo_q);
    end
  end

  assign done_o = done_q;

endmodule

[hw/rtl/top_n_cosine_similarity_search.sv]
// Top-N cosine similarity search over streamed Q8.16 vectors, store in on-chip memory.
// Elements are taken one per cycle while idle. A finished vector first gets its square root,
// then MAX_LENGTH element passes that divide in-length elements by a nonzero root;
// a query then scans each reference and emits top_n items, one per cycle unless stalled.
// Reset clears all control state; store contents stay undefined and are always written
// in full rows before they are read, so no clearing pass is needed.
module top_n_cosine_similarity_search #(
  parameter int MAX_REFERENCES = tncs_pkg::DEF_MAX_REFERENCES,
  parameter int MAX_LENGTH     = tncs_pkg::DEF_MAX_LENGTH,
  parameter int MAX_TOP        = tncs_pkg::DEF_MAX_TOP
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  tncs_pkg::in_item_t        in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output tncs_pkg::out_item_t       out_item_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [tncs_pkg::CFG_W-1:0] cfg_data_i
);
  import tncs_pkg::*;

  localparam int LW    = $clog2(MAX_LENGTH + 1);
  localparam int IW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int CW    = $clog2(MAX_REFERENCES + 1);
  localparam int DEPTH = MAX_REFERENCES * MAX_LENGTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(MAX_TOP + 1);
  localparam int EW    = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
  localparam int ACC_W = 33 + $clog2(MAX_LENGTH);

  state_e state_q, state_d;

  logic [8:0]  vl_q;
  logic [4:0]  top_q;
  logic [LW-1:0] len, pos_q, si_q;
  logic [NW-1:0] n;
  logic [IW-1:0] ni_q;
  logic [CW-1:0] ref_cnt_q, c_q;
  logic [AW-1:0] wbase_q, rbase_q;
  logic [EW-1:0] ea_q;
  logic [23:0] qcnt_q;
  logic        kind_q;

  logic [ELEM_W-1:0] buf_mem [MAX_LENGTH];
  logic [UNIT_W-1:0] q_mem [MAX_LENGTH];
  logic [UNIT_W-1:0] store_mem [DEPTH];
  logic signed [ELEM_W-1:0] buf_rd_q;
  logic signed [UNIT_W-1:0] sd_q, qd_q;

  logic [2*ELEM_W-1:0] prod_sq_q;
  logic                prod_sq_v_q;
  logic [SQ_W-1:0]     sq_q, sq_d;
  logic [ROOT_W-1:0]   r_q, root;
  logic                root_done, div_done;
  logic signed [UNIT_W-1:0] div_q;

  logic signed [31:0]      prod_q;
  logic                    rv_q, pv_q;
  logic signed [ACC_W-1:0] acc_q, acc_t, acc_sh;
  logic signed [UNIT_W-1:0] score;

  logic signed [UNIT_W-1:0] best_s_q [MAX_TOP];
  logic [CW-1:0]            best_i_q [MAX_TOP];
  logic [MAX_TOP-1:0]       hit;

  out_item_t out_q;
  logic      out_valid_q;

  logic in_acc, root_start, div_start, norm_we, issue, emit_load, use_div, last_ni, adv;
  logic [UNIT_W-1:0] norm_val;

  assign len = ({23'b0, vl_q} > 32'(MAX_LENGTH)) ? LW'(MAX_LENGTH) : LW'(vl_q);
  always_comb begin
    if (top_q == 5'd0) n = NW'(1);
    else if ({27'b0, top_q} > 32'(MAX_TOP)) n = NW'(MAX_TOP);
    else n = NW'(top_q);
  end

  assign in_acc  = in_valid_i && !in_stall_o;
  assign use_div = (LW'(ni_q) < pos_q) && (r_q != '0);
  assign last_ni = (ni_q == IW'(MAX_LENGTH - 1));
  assign sq_d    = prod_sq_v_q ? sq_q + SQ_W'(prod_sq_q) : sq_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_acc && in_item_i.last_element) state_d = ST_SQ_WAIT;
      ST_SQ_WAIT: begin
        if (kind_q == KIND_REFERENCE && ref_cnt_q == CW'(MAX_REFERENCES)) state_d = ST_IDLE;
        else state_d = ST_ROOT;
      end
      ST_ROOT:     if (root_done) state_d = ST_NORM_RD;
      ST_NORM_RD:  state_d = ST_NORM_DAT;
      ST_NORM_DAT: begin
        if (use_div) state_d = ST_NORM_DIV;
        else if (!last_ni) state_d = ST_NORM_RD;
        else state_d = (kind_q == KIND_REFERENCE) ? ST_IDLE : ST_SCAN;
      end
      ST_NORM_DIV: begin
        if (div_done) begin
          if (!last_ni) state_d = ST_NORM_RD;
          else state_d = (kind_q == KIND_REFERENCE) ? ST_IDLE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (c_q == ref_cnt_q || len == '0) state_d = ST_EMIT;
        else state_d = ST_ISSUE;
      end
      ST_ISSUE:    if (si_q == len - 1'b1) state_d = ST_DRAIN;
      ST_DRAIN:    if (!rv_q && !pv_q) state_d = ST_RANK;
      ST_RANK:     state_d = ST_SCAN;
      ST_EMIT:     if (emit_load && ea_q == EW'(n - 1'b1)) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Strobes.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    root_start = 1'b0;
    div_start  = 1'b0;
    norm_we    = 1'b0;
    norm_val   = '0;
    issue      = 1'b0;
    emit_load  = 1'b0;
    case (state_q)
      ST_SQ_WAIT:  root_start = (state_d == ST_ROOT);
      ST_NORM_DAT: begin
        div_start = use_div;
        norm_we   = !use_div;
      end
      ST_NORM_DIV: begin
        norm_we  = div_done;
        norm_val = div_q;
      end
      ST_ISSUE:    issue = 1'b1;
      ST_EMIT:     emit_load = !out_valid_q || !out_stall_i;
      default:     norm_we = 1'b0;
    endcase
  end
  assign adv = norm_we;

  tncs_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .x_i     (sq_d),
    .done_o  (root_done),
    .root_o  (root)
  );

  tncs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .e_i     (buf_rd_q),
    .r_i     (r_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // Memories.
  always_ff @(posedge clk_i) begin
    if (in_acc && pos_q < len) buf_mem[pos_q[IW-1:0]] <= in_item_i.element_value;
    buf_rd_q <= buf_mem[ni_q];
  end

  always_ff @(posedge clk_i) begin
    if (norm_we && kind_q != KIND_REFERENCE) q_mem[ni_q] <= norm_val;
    qd_q <= q_mem[si_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (norm_we && kind_q == KIND_REFERENCE) store_mem[wbase_q + AW'(ni_q)] <= norm_val;
    sd_q <= store_mem[rbase_q + AW'(si_q)];
  end

  // Score of the finished row, rounded to Q1.15 and saturated.
  assign acc_t  = acc_q + ACC_W'(16384);
  assign acc_sh = acc_t >>> 15;
  always_comb begin
    if (acc_sh > ACC_W'(32767)) score = 16'sd32767;
    else if (acc_sh < -ACC_W'(32768)) score = -16'sd32768;
    else score = UNIT_W'(acc_sh);
  end

  // The list is kept descending, so the hit pattern is a run from the insertion point on.
  always_comb begin
    for (int j = 0; j < MAX_TOP; j++) begin
      hit[j] = (NW'(j) < n) && (score > best_s_q[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vl_q        <= RESET_VECTOR_LENGTH;
      top_q       <= RESET_TOP_N;
      pos_q       <= '0;
      ni_q        <= '0;
      si_q        <= '0;
      ref_cnt_q   <= '0;
      c_q         <= '0;
      wbase_q     <= '0;
      rbase_q     <= '0;
      ea_q        <= '0;
      qcnt_q      <= '0;
      kind_q      <= 1'b0;
      sq_q        <= '0;
      prod_sq_v_q <= 1'b0;
      rv_q        <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < MAX_TOP; j++) begin
        best_s_q[j] <= '0;
        best_i_q[j] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_VECTOR_LENGTH) vl_q <= cfg_data_i;
        else vl_q <= vl_q;
        if (cfg_idx_i == CFG_TOP_N) top_q <= cfg_data_i[4:0];
      end

      prod_sq_v_q <= in_acc && (pos_q < len);
      if (state_q == ST_SQ_WAIT) sq_q <= '0;
      else sq_q <= sq_d;

      if (in_acc) begin
        kind_q <= in_item_i.kind;
        if (pos_q < len) pos_q <= pos_q + 1'b1;
      end

      if (state_q == ST_SQ_WAIT) begin
        ni_q <= '0;
        if (state_d == ST_IDLE) pos_q <= '0;
      end

      if (adv) begin
        ni_q <= ni_q + 1'b1;
        if (last_ni) begin
          pos_q <= '0;
          ni_q  <= '0;
          if (kind_q == KIND_REFERENCE) begin
            ref_cnt_q <= ref_cnt_q + 1'b1;
            wbase_q   <= wbase_q + AW'(MAX_LENGTH);
          end else begin
            qcnt_q  <= qcnt_q + 1'b1;
            c_q     <= '0;
            rbase_q <= '0;
            ea_q    <= '0;
            for (int j = 0; j < MAX_TOP; j++) begin
              best_s_q[j] <= '0;
              best_i_q[j] <= '0;
            end
          end
        end
      end

      if (state_q == ST_SCAN) si_q <= '0;
      else if (issue) si_q <= si_q + 1'b1;
      rv_q <= issue;
      pv_q <= rv_q;

      if (state_q == ST_RANK) begin
        for (int j = 0; j < MAX_TOP; j++) begin
          if (hit[j]) begin
            if (j == 0 || !hit[(j == 0) ? 0 : j - 1]) begin
              best_s_q[j] <= score;
              best_i_q[j] <= c_q + 1'b1;
            end else begin
              best_s_q[j] <= best_s_q[(j == 0) ? 0 : j - 1];
              best_i_q[j] <= best_i_q[(j == 0) ? 0 : j - 1];
            end
          end
        end
        c_q     <= c_q + 1'b1;
        rbase_q <= rbase_q + AW'(MAX_LENGTH);
      end

      if (emit_load) begin
        out_valid_q <= 1'b1;
        ea_q        <= ea_q + 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROOT && root_done) r_q <= root;
    prod_sq_q <= (2*ELEM_W)'(in_item_i.element_value * in_item_i.element_value);
    prod_q    <= sd_q * qd_q;
    if (state_q == ST_SCAN) acc_q <= '0;
    else if (pv_q) acc_q <= acc_q + ACC_W'(prod_q);
    if (emit_load) begin
      out_q.query_number    <= qcnt_q;
      out_q.rank            <= 4'(ea_q);
      out_q.reference_index <= 11'(best_i_q[ea_q]);
      out_q.score           <= best_s_q[ea_q];
      out_q.last_result     <= (ea_q == EW'(n - 1'b1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
